// ----- design/csim_pkg.sv -----
package csim_pkg;

  // Element and accumulator sizes
  localparam int ELEM_BITS = 16;
  localparam int ACC_BITS  = 48;

  // Fraction bits of the Q1.15 result and width of the result field
  localparam int Q_BITS   = 15;
  localparam int SIM_BITS = 16;

  // Stream packing
  localparam int IN_DATA_BITS  = ((2 * ELEM_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SIM_BITS + 7) / 8) * 8;

  // Final-stage arithmetic: half-width partial products, full products, root compare
  localparam int HALF_BITS = (ACC_BITS + 1) / 2;
  localparam int MUL_BITS  = 4 * HALF_BITS;
  localparam int ROOT_BITS = MUL_BITS + 2 * Q_BITS;

  // Queue between accumulator front and root/divide back
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [ACC_BITS-1:0] acc_t;

  // One finished set of sums, handed from front to back
  typedef struct packed {
    acc_t dot;
    acc_t norm_a;
    acc_t norm_b;
  } acc_set_t;

endpackage

// ----- design/csim_front.sv -----
module csim_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [csim_pkg::IN_DATA_BITS-1:0]    s_tdata,
  input  logic                                 s_tlast,
  output logic                                 push,
  output csim_pkg::acc_set_t                   push_data,
  input  logic                                 q_full
);

  localparam int PROD_BITS = 2 * csim_pkg::ELEM_BITS;
  localparam int SUM_BITS  = ((PROD_BITS > csim_pkg::ACC_BITS) ? PROD_BITS
                                                                : csim_pkg::ACC_BITS) + 1;
  localparam logic signed [csim_pkg::ACC_BITS-1:0] ACC_MAX =
    {1'b0, {(csim_pkg::ACC_BITS-1){1'b1}}};
  localparam logic signed [csim_pkg::ACC_BITS-1:0] ACC_MIN =
    {1'b1, {(csim_pkg::ACC_BITS-1){1'b0}}};

  // Saturating add of one product into an accumulator
  function automatic csim_pkg::acc_t sat_add(csim_pkg::acc_t acc,
                                             logic signed [PROD_BITS-1:0] p);
    logic signed [SUM_BITS-1:0] s;
    s = SUM_BITS'(acc) + SUM_BITS'(p);
    if (s > SUM_BITS'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (s < SUM_BITS'(ACC_MIN)) begin
      return ACC_MIN;
    end else begin
      return s[csim_pkg::ACC_BITS-1:0];
    end
  endfunction

  logic signed [csim_pkg::ELEM_BITS-1:0] elem_a;
  logic signed [csim_pkg::ELEM_BITS-1:0] elem_b;
  logic                                  take;
  logic                                  stall;
  logic                                  retire;

  // Product stage
  logic                                  s1_valid;
  logic                                  s1_last;
  logic signed [PROD_BITS-1:0]           p_ab;
  logic signed [PROD_BITS-1:0]           p_aa;
  logic signed [PROD_BITS-1:0]           p_bb;

  // Running sums
  csim_pkg::acc_t dot_acc;
  csim_pkg::acc_t norm_a_acc;
  csim_pkg::acc_t norm_b_acc;
  csim_pkg::acc_set_t sums;

  assign elem_a = s_tdata[csim_pkg::ELEM_BITS-1:0];
  assign elem_b = s_tdata[2*csim_pkg::ELEM_BITS-1:csim_pkg::ELEM_BITS];

  // Only a last pair facing a full queue holds the pipe
  assign stall    = s1_valid && s1_last && q_full;
  assign s_tready = !stall;
  assign take     = s_tvalid && s_tready;
  assign retire   = s1_valid && !stall;

  // Product registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_last <= s_tlast;
      p_ab    <= PROD_BITS'(elem_a) * PROD_BITS'(elem_b);
      p_aa    <= PROD_BITS'(elem_a) * PROD_BITS'(elem_a);
      p_bb    <= PROD_BITS'(elem_b) * PROD_BITS'(elem_b);
    end
  end

  // Sums including the product stage
  always_comb begin
    sums.dot    = sat_add(dot_acc, p_ab);
    sums.norm_a = sat_add(norm_a_acc, p_aa);
    sums.norm_b = sat_add(norm_b_acc, p_bb);
  end

  // Accumulators, cleared after the last pair of a vector
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc    <= '0;
      norm_a_acc <= '0;
      norm_b_acc <= '0;
    end else if (retire) begin
      if (s1_last) begin
        dot_acc    <= '0;
        norm_a_acc <= '0;
        norm_b_acc <= '0;
      end else begin
        dot_acc    <= sums.dot;
        norm_a_acc <= sums.norm_a;
        norm_b_acc <= sums.norm_b;
      end
    end
  end

  assign push      = retire && s1_last;
  assign push_data = sums;

endmodule

// ----- design/csim_queue.sv -----
module csim_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  csim_pkg::acc_set_t push_data,
  input  logic               pop,
  output csim_pkg::acc_set_t head,
  output logic               full,
  output logic               empty
);

  csim_pkg::acc_set_t                entries [csim_pkg::QUEUE_DEPTH];
  logic [csim_pkg::PTR_BITS-1:0]     wr_ptr;
  logic [csim_pkg::PTR_BITS-1:0]     rd_ptr;
  logic [csim_pkg::CNT_BITS-1:0]     count;

  function automatic logic [csim_pkg::PTR_BITS-1:0] ptr_inc(
    logic [csim_pkg::PTR_BITS-1:0] p);
    if (p == csim_pkg::PTR_BITS'(csim_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end else begin
      return p + csim_pkg::PTR_BITS'(1);
    end
  endfunction

  assign full  = (count == csim_pkg::CNT_BITS'(csim_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + csim_pkg::CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - csim_pkg::CNT_BITS'(1);
      end
    end
  end

endmodule

// ----- design/csim_back.sv -----
module csim_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_empty,
  input  csim_pkg::acc_set_t                    q_head,
  output logic                                  pop,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [csim_pkg::OUT_DATA_BITS-1:0]    m_tdata,
  output logic                                  m_tuser
);

  localparam int H         = csim_pkg::HALF_BITS;
  localparam int A         = csim_pkg::ACC_BITS;
  localparam int W         = csim_pkg::ROOT_BITS;
  localparam int MB        = csim_pkg::MUL_BITS;
  localparam int QB        = csim_pkg::Q_BITS;
  localparam int MUL_STEPS = 8;
  localparam int MCNT_BITS = $clog2(MUL_STEPS + 1);
  localparam int BIT_BITS  = $clog2(QB);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PRE  = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;

  // Operands of the current request
  logic [A-1:0]            dmag;
  logic [A-1:0]            na;
  logic [A-1:0]            nb;
  logic                    dot_neg;
  logic                    zero;

  // Shared half-width multiplier
  logic [MCNT_BITS-1:0]    mcnt;
  logic [2*H-1:0]          xop;
  logic [2*H-1:0]          yop;
  logic [H-1:0]            xh;
  logic [H-1:0]            yh;
  logic [2*H-1:0]          prod;
  logic [2:0]              pidx;
  logic                    prod_v;
  logic [MB-1:0]           prod_sh;
  logic [MB-1:0]           nn;
  logic [MB-1:0]           rr;
  logic [MB-1:0]           nn_next;
  logic [MB-1:0]           rr_next;

  // Root search: s = q^2*nn, tk = q*nn << (k+1), nk = nn << 2k
  logic [W-1:0]            s_acc;
  logic [W-1:0]            tk;
  logic [W-1:0]            nk;
  logic [W-1:0]            rq;
  logic [W-1:0]            pre_a;
  logic [W-1:0]            pre_b;
  logic [W-1:0]            cand;
  logic                    fit;
  logic [BIT_BITS-1:0]     bit_idx;
  logic [QB-1:0]           qmag;

  // Output register
  logic [csim_pkg::SIM_BITS-1:0] similarity;
  logic                          out_load;

  assign pop = (state == ST_IDLE) && !q_empty;

  // Operand select for the partial product of this step
  always_comb begin
    xop = mcnt[2] ? (2*H)'(dmag) : (2*H)'(na);
    yop = mcnt[2] ? (2*H)'(dmag) : (2*H)'(nb);
    xh  = mcnt[1] ? xop[2*H-1:H] : xop[H-1:0];
    yh  = mcnt[0] ? yop[2*H-1:H] : yop[H-1:0];
  end

  // Place the registered partial product by its half indexes
  always_comb begin
    case ({pidx[1], pidx[0]})
      2'b00:   prod_sh = MB'(prod);
      2'b11:   prod_sh = MB'(prod) << (2 * H);
      default: prod_sh = MB'(prod) << H;
    endcase
    nn_next = nn;
    rr_next = rr;
    if (prod_v) begin
      if (pidx[2]) begin
        rr_next = rr + prod_sh;
      end else begin
        nn_next = nn + prod_sh;
      end
    end
  end

  assign cand     = s_acc + pre_a;
  assign fit      = (cand <= rq);
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if ((q_head.norm_a == '0) || q_head.norm_a[A-1] ||
                (q_head.norm_b == '0) || q_head.norm_b[A-1]) begin
              state <= ST_DONE;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mcnt == MCNT_BITS'(MUL_STEPS)) begin
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (bit_idx == '0) begin
            state <= ST_DONE;
          end else begin
            state <= ST_PRE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        zero    <= (q_head.norm_a == '0) || q_head.norm_a[A-1] ||
                   (q_head.norm_b == '0) || q_head.norm_b[A-1];
        dot_neg <= q_head.dot[A-1];
        dmag    <= q_head.dot[A-1] ? A'(-q_head.dot) : A'(q_head.dot);
        na      <= q_head.norm_a;
        nb      <= q_head.norm_b;
        mcnt    <= '0;
        prod_v  <= 1'b0;
        nn      <= '0;
        rr      <= '0;
        qmag    <= '0;
      end
      ST_MUL: begin
        if (mcnt != MCNT_BITS'(MUL_STEPS)) begin
          prod   <= (2*H)'(xh) * (2*H)'(yh);
          pidx   <= mcnt[2:0];
          prod_v <= 1'b1;
        end else begin
          prod_v <= 1'b0;
        end
        nn   <= nn_next;
        rr   <= rr_next;
        mcnt <= mcnt + MCNT_BITS'(1);
        if (mcnt == MCNT_BITS'(MUL_STEPS)) begin
          nk      <= W'(nn_next) << (2 * (QB - 1));
          tk      <= '0;
          s_acc   <= '0;
          rq      <= {rr_next, (2*QB)'(0)};
          bit_idx <= BIT_BITS'(QB - 1);
        end
      end
      ST_PRE: begin
        pre_a <= tk + nk;
        pre_b <= tk + (nk << 1);
      end
      ST_CMP: begin
        if (fit) begin
          s_acc <= cand;
          qmag  <= qmag | (QB'(1) << bit_idx);
        end
        tk      <= (fit ? pre_b : tk) >> 1;
        nk      <= nk >> 2;
        bit_idx <= bit_idx - BIT_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  // Result register toward the receiver
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (zero) begin
        similarity <= '0;
      end else if (dot_neg) begin
        similarity <= -csim_pkg::SIM_BITS'(qmag);
      end else begin
        similarity <= csim_pkg::SIM_BITS'(qmag);
      end
      m_tuser <= zero;
    end
  end

  assign m_tdata = csim_pkg::OUT_DATA_BITS'(similarity);

  // Checks
  a_zero_gives_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (similarity == '0))
    else $error("zero-norm result with nonzero similarity");

  a_no_min_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (similarity != {1'b1, {(csim_pkg::SIM_BITS-1){1'b0}}}))
    else $error("similarity reached the negative limit");

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (mcnt <= MCNT_BITS'(MUL_STEPS)))
    else $error("multiply step count out of range");

  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != ST_IDLE))
    else $error("request popped but sequencer stayed idle");

endmodule

// ----- design/cosine_similarity_stream.sv -----
// Streaming cosine similarity of two signed Q1.15 vectors.
// Input channel (s_*): one element pair per request; s_tlast marks the final
// pair of the vectors. Each pair adds a*b, a*a and b*b into three saturating
// 48-bit sums. Pairs are taken one per clock while s_tready is high.
// Output channel (m_*): one request per vector pair, the similarity
// dot/sqrt(|a|^2*|b|^2) in Q1.15 truncated toward zero and clamped to
// +-32767; m_tuser is set with similarity 0 when either norm is zero.
// From the last pair to m_tvalid the steps are: products and sums, issue,
// the two wide products on one shared half-width multiplier, the 15-bit
// root search one bit at a time (ST_PRE then ST_CMP per bit), and the
// result register. A zero-norm vector skips the multiply and the root search.
// Throughput: elements at one per cycle while s_tready is high; the back
// stage works on one vector at a time, and a two-entry queue of finished
// sums sits in between. Short vectors can fill the queue and then hold
// s_tready low on their last pair until the back stage frees an entry.
// When m_tready is low the result stays in its register and the back stage
// waits; the front stalls only on a last pair that meets a full queue.
// Reset (rst, synchronous) clears the sums, the queue and the product-stage and output valid flags.
module cosine_similarity_stream (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [csim_pkg::IN_DATA_BITS-1:0]    s_tdata,   // elem_a, elem_b
  input  logic                                 s_tlast,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [csim_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // similarity
  output logic                                 m_tuser    // zero_norm
);

  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  csim_pkg::acc_set_t push_data;
  csim_pkg::acc_set_t q_head;

  // Accumulating front
  csim_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // Finished sums awaiting the back stage
  csim_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Root and divide back stage
  csim_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ----- sim/cosine_similarity_stream_tb.sv -----
module cosine_similarity_stream_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EW = csim_pkg::ELEM_BITS;
  localparam int SW = csim_pkg::SIM_BITS;
  localparam longint ACC_HI = (64'sd1 <<< (csim_pkg::ACC_BITS - 1)) - 1;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int EXTREME_RUN_LEN = 100;
  localparam int RANDOM_PAIRS = 1680;

  typedef logic signed [EW-1:0] elem_t;

  typedef struct packed {
    logic signed [SW-1:0] sim;
    logic                 zn;
  } cos_res_t;

  typedef struct {
    elem_t                a;
    elem_t                b;
    bit                   last;
    bit                   fixed;
    logic signed [SW-1:0] sim;
    bit                   zn;
  } pair_row_t;

  logic                                clk;
  logic                                rst;
  logic                                s_tvalid;
  logic                                s_tready;
  logic [csim_pkg::IN_DATA_BITS-1:0]   s_tdata;   // elem_a, elem_b
  logic                                s_tlast;
  logic                                m_tvalid;
  logic                                m_tready;
  logic [csim_pkg::OUT_DATA_BITS-1:0]  m_tdata;   // similarity
  logic                                m_tuser;   // zero_norm

  // typed-in expectation travelling with the request on the input side
  bit                   row_fixed;
  logic signed [SW-1:0] row_sim;
  bit                   row_zn;

  csim_pkg::acc_t dot_sum, sq_a_sum, sq_b_sum;
  cos_res_t       pending_sims[$];
  int             errors;
  int             n_results;
  int             idle_cycles;
  bit             send_calm;

  cosine_similarity_stream dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  task automatic flag_error(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  function automatic csim_pkg::acc_t sat_acc(input csim_pkg::acc_t acc, input longint p);
    longint s;
    s = longint'(acc) + p;
    if (s > ACC_HI) return csim_pkg::acc_t'(ACC_HI);
    if (s < ACC_LO) return csim_pkg::acc_t'(ACC_LO);
    return csim_pkg::acc_t'(s);
  endfunction

  // Add one pair to the sums; on the last pair, work out the similarity and clear.
  function automatic cos_res_t fold_pair(input elem_t a, input elem_t b, input bit last);
    cos_res_t             res;
    logic [63:0]          dmag;
    logic [191:0]         rhs, nn, qq;
    logic [15:0]          q, cand;
    res      = '0;
    dot_sum  = sat_acc(dot_sum, longint'(a) * longint'(b));
    sq_a_sum = sat_acc(sq_a_sum, longint'(a) * longint'(a));
    sq_b_sum = sat_acc(sq_b_sum, longint'(b) * longint'(b));
    if (!last) return res;
    if (sq_a_sum <= 0 || sq_b_sum <= 0) begin
      res.sim = '0;
      res.zn  = 1'b1;
    end else begin
      dmag = (dot_sum < 0) ? 64'(-longint'(dot_sum)) : 64'(longint'(dot_sum));
      rhs  = (192'(dmag) * 192'(dmag)) << 30;
      nn   = 192'(64'(sq_a_sum)) * 192'(64'(sq_b_sum));
      // largest q with q*q*|A|^2*|B|^2 <= dot^2 * 2^30, one bit at a time
      q = '0;
      for (int k = 14; k >= 0; k--) begin
        cand = q | (16'd1 << k);
        qq   = 192'(cand) * 192'(cand) * nn;
        if (qq <= rhs) q = cand;
      end
      res.sim = (dot_sum < 0) ? -$signed(q) : $signed(q);
      res.zn  = 1'b0;
    end
    dot_sum  = '0;
    sq_a_sum = '0;
    sq_b_sum = '0;
    return res;
  endfunction

  // mostly back-to-back, sometimes a short gap, rarely a long gap
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0:       return elem_t'(-32768);
      1:       return elem_t'(32767);
      2:       return '0;
      3:       return elem_t'($signed($urandom_range(0, 31)) - 16);
      default: return elem_t'($urandom());
    endcase
  endfunction

  // Offer one pair, hold it until taken, then maybe idle.
  task automatic send_pair(input elem_t a, input elem_t b, input bit last,
                           input bit fixed, input logic signed [SW-1:0] sim, input bit zn);
    int g;
    s_tvalid  <= 1'b1;
    s_tdata   <= {b, a};
    s_tlast   <= last;
    row_fixed <= fixed;
    row_sim   <= sim;
    row_zn    <= zn;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    g = send_calm ? 0 : pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  // Stop offering until every pending similarity has come back.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    while (pending_sims.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Predict on accepted pairs, check accepted results, watch for a hang.
  always @(posedge clk) begin
    cos_res_t pred, want;
    if (rst) begin
      dot_sum     = '0;
      sq_a_sum    = '0;
      sq_b_sum    = '0;
      idle_cycles = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (pending_sims.size() == 0) begin
          flag_error($sformatf("unexpected result sim=%0d zn=%0b",
                               $signed(m_tdata[SW-1:0]), m_tuser));
        end else begin
          want = pending_sims.pop_front();
          if ($signed(m_tdata[SW-1:0]) !== want.sim)
            flag_error($sformatf("result %0d similarity %0d, expected %0d", n_results,
                                 $signed(m_tdata[SW-1:0]), want.sim));
          if (m_tuser !== want.zn)
            flag_error($sformatf("result %0d zero_norm %0b, expected %0b", n_results,
                                 m_tuser, want.zn));
        end
      end
      if (s_tvalid && s_tready) begin
        pred = fold_pair(elem_t'(s_tdata[EW-1:0]), elem_t'(s_tdata[2*EW-1:EW]), s_tlast);
        if (s_tlast)
          pending_sims.insert(pending_sims.size(),
                              row_fixed ? cos_res_t'{row_sim, row_zn} : pred);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Receiver: random back-pressure, calm stretches, one long hold-off.
  initial begin
    int  hold;
    bit  held, calm;
    hold = 0;
    held = 1'b0;
    calm = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (!held && n_results >= 40) begin
        hold = 500;
        held = 1'b1;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 199) == 0) calm = !calm;
        if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Sender: directed table, a long run of extreme pairs, then random vectors.
  initial begin
    pair_row_t directed[$];
    int        pairs, len, kind, sh;
    bit        paused;
    elem_t     a, b;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    row_fixed = 1'b0;
    row_sim   = '0;
    row_zn    = 1'b0;
    errors    = 0;
    n_results = 0;
    send_calm = 1'b0;
    directed = '{
      // single-pair vectors at the extremes
      '{ 32767,  32767, 1, 1,  32767, 0},
      '{-32768, -32768, 1, 1,  32767, 0},
      '{-32768,  32767, 1, 1, -32767, 0},
      '{ 32767, -32768, 1, 1, -32767, 0},
      // zero norm on either side or both
      '{     0, -32768, 1, 1,      0, 1},
      '{ 32767,      0, 1, 1,      0, 1},
      '{     0,      0, 1, 1,      0, 1},
      // orthogonal vectors, with an anti-parallel single pair between them
      '{     1,      0, 0, 0,      0, 0},
      '{     0,      1, 1, 1,      0, 0},
      '{     1,     -1, 1, 1, -32767, 0},
      '{     3,      4, 0, 0,      0, 0},
      '{     4,     -3, 1, 1,      0, 0},
      // leading zero pairs, anti-parallel, then orthogonal
      '{     0,      0, 0, 0,      0, 0},
      '{     0,      0, 0, 0,      0, 0},
      '{     5,     -5, 1, 1, -32767, 0},
      '{     0,      7, 0, 0,      0, 0},
      '{     9,      0, 1, 1,      0, 0},
      // general vectors, predicted
      '{   100,    200, 0, 0,      0, 0},
      '{  -300,     50, 0, 0,      0, 0},
      '{     7,     -7, 1, 0,      0, 0},
      '{    -1,  32767, 0, 0,      0, 0},
      '{ 12345,     -2, 0, 0,      0, 0},
      '{-32768, -32768, 1, 0,      0, 0},
      '{ 16384,  32767, 1, 0,      0, 0},
      '{-32767,      1, 1, 0,      0, 0}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_pair(directed[i].a, directed[i].b, directed[i].last,
                directed[i].fixed, directed[i].sim, directed[i].zn);
    wait_for_results();

    // long vector of the largest products, sent back to back
    send_calm = 1'b1;
    for (int i = 0; i < EXTREME_RUN_LEN; i++)
      send_pair(elem_t'(-32768), elem_t'(32767), i == EXTREME_RUN_LEN - 1, 0, '0, 0);
    send_calm = 1'b0;
    wait_for_results();

    // random vectors: mostly short, some parallel, scaled or zero
    pairs  = 0;
    paused = 1'b0;
    while (pairs < RANDOM_PAIRS) begin
      case ($urandom_range(0, 19)) inside
        [0:13]:  len = $urandom_range(1, 4);
        [14:18]: len = $urandom_range(5, 20);
        default: len = $urandom_range(21, 80);
      endcase
      kind = $urandom_range(0, 11);
      sh   = $urandom_range(0, 15);
      if ($urandom_range(0, 6) == 0) send_calm = !send_calm;
      for (int i = 0; i < len; i++) begin
        a = rand_elem();
        case (kind)
          0:       b = a;
          1:       b = -a;
          2:       b = a >>> sh;
          3:       begin b = rand_elem(); a = '0; end
          4:       b = '0;
          default: b = rand_elem();
        endcase
        send_pair(a, b, i == len - 1, 0, '0, 0);
        pairs++;
      end
      if (!paused && pairs >= RANDOM_PAIRS / 2) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
    wait_for_results();

    repeat (64) @(posedge clk);
    if (pending_sims.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_sims.size()));
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
